### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/kst_pkg.sv
// ---------------------------------------------------------------------------
// kst_pkg
// Commands, status codes and stream layout of the knock sequence tracker.
// ---------------------------------------------------------------------------
package kst_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [2:0] result_code_t;

	localparam cmd_t CMD_PACKET = 2'd0;
	localparam cmd_t CMD_STEP   = 2'd1;
	localparam cmd_t CMD_HEADER = 2'd2;

	localparam result_code_t ST_IGNORED  = 3'd0;
	localparam result_code_t ST_STARTED  = 3'd1;
	localparam result_code_t ST_ADVANCED = 3'd2;
	localparam result_code_t ST_OPENED   = 3'd3;
	localparam result_code_t ST_FULL     = 3'd4;
	localparam result_code_t ST_WRITTEN  = 3'd5;

	// Door count and steps per door are fixed by the selector and length fields.
	localparam int NUM_DOORS = 4;
	localparam int SEQ_STEPS = 32;

	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 48;

	localparam logic [15:0] DEFAULT_TIME_LIMIT = 16'd5;
	localparam logic [4:0]  EXPIRED_MAX        = 5'd31;

endpackage

### src/kst_ram.sv
// ---------------------------------------------------------------------------
// kst_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic                                 rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/knock_sequence_tracker.sv
// ---------------------------------------------------------------------------
// knock_sequence_tracker
// Tracks port-knock attempts per source address and reports the outcome of each packet, such as an opened door.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser command, s_tdata packet/write fields
// m_*       out  m_tvalid/m_tready  m_tuser status, m_tdata result fields
//
// A write transfer goes straight to the output state, which loads its result
// once the output register is free, and then returns to idle.
// A packet first walks the attempt RAM one slot per cycle, then reads the
// knock step RAM once for the attempt found for its source, or up to once
// per door when a new attempt is searched for; the output state then loads
// the result and the block returns to idle for the next input transfer.
// Reset clears the attempt valid bits and the door step counts and default
// flags, and sets each door time limit to DEFAULT_TIME_LIMIT; both RAMs need
// no clearing pass. A new input is taken only in the idle state, and a
// result waiting on m_tready does not block the next input transfer.
//
`include "assert_macros.svh"

module knock_sequence_tracker
	import kst_pkg::*;
#(
	parameter int TRY_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// From bit 0: src_ip, dst_port, packet_flags, now_seconds, door_sel, step_sel,
	// step_port, step_flags, door_length, door_timeout, door_flags, zero fill.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// From bit 0: door_index, opener_ip, progress, expired_count, zero fill.
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [2:0]            m_tuser
);

	localparam int DW  = (NUM_DOORS > 1) ? $clog2(NUM_DOORS) : 1;
	localparam int DCW = $clog2(NUM_DOORS + 1);
	localparam int MW  = (SEQ_STEPS > 1) ? $clog2(SEQ_STEPS) : 1;
	localparam int PW  = $clog2(SEQ_STEPS + 1);
	localparam int SW  = (TRY_SLOTS > 1) ? $clog2(TRY_SLOTS) : 1;
	localparam int CW  = $clog2(TRY_SLOTS + 1);
	localparam int KD  = NUM_DOORS * SEQ_STEPS;
	localparam int KAW = (KD > 1) ? $clog2(KD) : 1;
	localparam int SLW = 64 + DW + MW;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_DSCAN, S_STEP_RD, S_STEP_CHK, S_OUT
	} state_t;

	// Input fields.
	logic [31:0] in_ip, in_now;
	logic [15:0] in_port, in_step_port, in_timeout;
	logic [6:0]  in_flags, in_step_flags, in_door_flags;
	logic [1:0]  in_dsel;
	logic [4:0]  in_ssel;
	logic [5:0]  in_len;

	assign in_ip         = s_tdata[31:0];
	assign in_port       = s_tdata[47:32];
	assign in_flags      = s_tdata[54:48];
	assign in_now        = s_tdata[86:55];
	assign in_dsel       = s_tdata[88:87];
	assign in_ssel       = s_tdata[93:89];
	assign in_step_port  = s_tdata[109:94];
	assign in_step_flags = s_tdata[116:110];
	assign in_len        = s_tdata[122:117];
	assign in_timeout    = s_tdata[138:123];
	assign in_door_flags = s_tdata[145:139];

	state_t          state_q;
	logic [31:0]     ip_q, now_q, start_q;
	logic [15:0]     port_q;
	logic [6:0]      flags_q;
	logic [CW-1:0]   cnt_q, exp_cnt_q;
	logic            chk_vld_s1;
	logic [SW-1:0]   chk_idx_s1;
	logic [DCW-1:0]  dcnt_q;
	logic            dchk_vld_s1;
	logic [DW-1:0]   dchk_idx_s1;
	logic            found_q, free_ok_q;
	logic [SW-1:0]   slot_q, free_q;
	logic [DW-1:0]   door_q;
	logic [MW-1:0]   match_q;
	logic            slot_valid_q [TRY_SLOTS];
	logic [PW-1:0]   steps_q [NUM_DOORS];
	logic [15:0]     lim_q [NUM_DOORS];
	logic [6:0]      dflt_q [NUM_DOORS];
	result_code_t    res_status_q;
	logic [1:0]      res_door_q;
	logic [31:0]     res_ip_q;
	logic [5:0]      res_prog_q;
	logic [4:0]      res_exp_q;

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Write command checks.
	logic dsel_ok, ssel_ok;
	assign dsel_ok = int'(in_dsel) < NUM_DOORS;
	assign ssel_ok = int'(in_ssel) < SEQ_STEPS;

	// Attempt RAM: {start, matched, door, source}.
	logic           sl_wr_en, sl_rd_en;
	logic [SW-1:0]  sl_wr_addr;
	logic [SLW-1:0] sl_wr_data, sl_rd_data;
	logic [31:0]    sl_src, sl_start;
	logic [DW-1:0]  sl_door;
	logic [MW-1:0]  sl_match;

	assign sl_rd_en  = (state_q == S_SCAN) && (int'(cnt_q) < TRY_SLOTS);
	assign sl_src    = sl_rd_data[31:0];
	assign sl_door   = sl_rd_data[32 +: DW];
	assign sl_match  = sl_rd_data[32 + DW +: MW];
	assign sl_start  = sl_rd_data[32 + DW + MW +: 32];

	kst_ram #(.WIDTH(SLW), .DEPTH(TRY_SLOTS)) u_slot_ram (
		.clk     (clk),
		.wr_en   (sl_wr_en),
		.wr_addr (sl_wr_addr),
		.wr_data (sl_wr_data),
		.rd_en   (sl_rd_en),
		.rd_addr (cnt_q[SW-1:0]),
		.rd_data (sl_rd_data)
	);

	// Knock step RAM: {flags, port} at door * SEQ_STEPS + step.
	logic            k_wr_en, k_rd_en;
	logic [KAW-1:0]  k_wr_addr, k_rd_addr;
	logic [22:0]     k_rd_data;

	assign k_wr_en   = accept && (s_tuser == CMD_STEP) && dsel_ok && ssel_ok;
	assign k_wr_addr = KAW'(int'(in_dsel) * SEQ_STEPS + int'(in_ssel));
	assign k_rd_en   = (state_q == S_STEP_RD) ||
		((state_q == S_DSCAN) && (int'(dcnt_q) < NUM_DOORS));
	assign k_rd_addr = (state_q == S_STEP_RD) ?
		KAW'(int'(door_q) * SEQ_STEPS + int'(match_q)) :
		KAW'(int'(dcnt_q) * SEQ_STEPS);

	kst_ram #(.WIDTH(23), .DEPTH(KD)) u_knock_ram (
		.clk     (clk),
		.wr_en   (k_wr_en),
		.wr_addr (k_wr_addr),
		.wr_data ({in_step_flags, in_step_port}),
		.rd_en   (k_rd_en),
		.rd_addr (k_rd_addr),
		.rd_data (k_rd_data)
	);

	// Single read port into the door headers, steered by the current phase.
	logic [DW-1:0] dr_idx;
	logic [PW-1:0] d_steps;
	logic [15:0]   d_lim;
	logic [6:0]    d_dflt;

	always_comb begin
		unique case (state_q)
			S_SCAN:  dr_idx = sl_door;
			S_DSCAN: dr_idx = dchk_idx_s1;
			default: dr_idx = door_q;
		endcase
	end

	assign d_steps = steps_q[dr_idx];
	assign d_lim   = lim_q[dr_idx];
	assign d_dflt  = dflt_q[dr_idx];

	// Shared slot compare unit: expiry, source match and stale check.
	logic expire, src_hit, stale;
	assign expire  = ({1'b0, sl_start} + {17'd0, d_lim}) < {1'b0, now_q};
	assign src_hit = (sl_src == ip_q);
	assign stale   = PW'(sl_match) >= d_steps;

	// Knock step compare: a zero flag set stands for the door default.
	logic [6:0] k_flags_eff;
	logic       k_match;
	assign k_flags_eff = (k_rd_data[22:16] != 7'd0) ? k_rd_data[22:16] : d_dflt;
	assign k_match     = (k_rd_data[15:0] == port_q) && (k_flags_eff == flags_q);

	// Attempt update after a matching step, for a new or an existing attempt.
	logic          upd_new;
	logic [SW-1:0] upd_slot;
	logic [MW-1:0] upd_match;
	logic [31:0]   upd_start;
	logic [PW-1:0] new_prog;
	logic          opened;

	assign upd_new   = (state_q == S_DSCAN);
	assign upd_slot  = upd_new ? free_q : slot_q;
	assign upd_match = upd_new ? '0 : match_q;
	assign upd_start = upd_new ? now_q : start_q;
	assign new_prog  = PW'(upd_match) + PW'(1);
	assign opened    = new_prog >= d_steps;

	logic dhit, upd_go;
	assign dhit   = (state_q == S_DSCAN) && dchk_vld_s1 && (d_steps != '0) && k_match;
	assign upd_go = (dhit && free_ok_q) || ((state_q == S_STEP_CHK) && k_match);

	assign sl_wr_en   = upd_go && !opened;
	assign sl_wr_addr = upd_slot;
	assign sl_wr_data = {upd_start, MW'(new_prog), dr_idx, ip_q};

	logic [4:0] exp_sat;
	assign exp_sat = (int'(exp_cnt_q) > int'(EXPIRED_MAX)) ? EXPIRED_MAX : 5'(exp_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ip_q         <= '0;
			now_q        <= '0;
			start_q      <= '0;
			port_q       <= '0;
			flags_q      <= '0;
			cnt_q        <= '0;
			exp_cnt_q    <= '0;
			chk_vld_s1   <= 1'b0;
			chk_idx_s1   <= '0;
			dcnt_q       <= '0;
			dchk_vld_s1  <= 1'b0;
			dchk_idx_s1  <= '0;
			found_q      <= 1'b0;
			free_ok_q    <= 1'b0;
			slot_q       <= '0;
			free_q       <= '0;
			door_q       <= '0;
			match_q      <= '0;
			res_status_q <= ST_IGNORED;
			res_door_q   <= '0;
			res_ip_q     <= '0;
			res_prog_q   <= '0;
			res_exp_q    <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
			for (int i = 0; i < TRY_SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
			end
			for (int d = 0; d < NUM_DOORS; d++) begin
				steps_q[d] <= '0;
				lim_q[d]   <= DEFAULT_TIME_LIMIT;
				dflt_q[d]  <= '0;
			end
		end else begin
			// The output stage reloads m_tvalid itself while it hands over a result.
			if (m_tvalid && m_tready && (state_q != S_OUT)) begin
				m_tvalid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ip_q         <= in_ip;
						now_q        <= in_now;
						port_q       <= in_port;
						flags_q      <= in_flags;
						cnt_q        <= '0;
						exp_cnt_q    <= '0;
						chk_vld_s1   <= 1'b0;
						found_q      <= 1'b0;
						free_ok_q    <= 1'b0;
						res_door_q   <= '0;
						res_ip_q     <= '0;
						res_prog_q   <= '0;
						res_exp_q    <= '0;
						unique case (s_tuser)
							CMD_PACKET: begin
								res_status_q <= ST_IGNORED;
								state_q      <= S_SCAN;
							end
							CMD_STEP: begin
								res_status_q <= (dsel_ok && ssel_ok) ?
									ST_WRITTEN : ST_IGNORED;
								state_q      <= S_OUT;
							end
							CMD_HEADER: begin
								if (dsel_ok) begin
									steps_q[DW'(in_dsel)] <= (int'(in_len) > SEQ_STEPS) ?
										PW'(SEQ_STEPS) : PW'(in_len);
									lim_q[DW'(in_dsel)]   <= in_timeout;
									dflt_q[DW'(in_dsel)]  <= in_door_flags;
								end
								res_status_q <= dsel_ok ? ST_WRITTEN : ST_IGNORED;
								state_q      <= S_OUT;
							end
							default: begin
								res_status_q <= ST_IGNORED;
								state_q      <= S_OUT;
							end
						endcase
					end
				end

				S_SCAN: begin
					chk_vld_s1 <= sl_rd_en;
					chk_idx_s1 <= cnt_q[SW-1:0];
					if (sl_rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (chk_vld_s1) begin
						if (!slot_valid_q[chk_idx_s1]) begin
							if (!free_ok_q) begin
								free_ok_q <= 1'b1;
								free_q    <= chk_idx_s1;
							end
						end else if (expire) begin
							slot_valid_q[chk_idx_s1] <= 1'b0;
							exp_cnt_q                <= exp_cnt_q + CW'(1);
							if (!free_ok_q) begin
								free_ok_q <= 1'b1;
								free_q    <= chk_idx_s1;
							end
						end else if (!found_q && src_hit) begin
							if (stale) begin
								slot_valid_q[chk_idx_s1] <= 1'b0;
								if (!free_ok_q) begin
									free_ok_q <= 1'b1;
									free_q    <= chk_idx_s1;
								end
							end else begin
								found_q <= 1'b1;
								slot_q  <= chk_idx_s1;
								door_q  <= sl_door;
								match_q <= sl_match;
								start_q <= sl_start;
							end
						end
					end else if (!sl_rd_en) begin
						dcnt_q      <= '0;
						dchk_vld_s1 <= 1'b0;
						state_q     <= found_q ? S_STEP_RD : S_DSCAN;
					end
				end

				S_DSCAN: begin
					dchk_vld_s1 <= k_rd_en;
					dchk_idx_s1 <= DW'(dcnt_q);
					if (k_rd_en) begin
						dcnt_q <= dcnt_q + DCW'(1);
					end
					res_exp_q <= exp_sat;
					if (dhit) begin
						state_q <= S_OUT;
						if (!free_ok_q) begin
							res_status_q <= ST_FULL;
							res_ip_q     <= ip_q;
						end
					end else if (!dchk_vld_s1 && !k_rd_en) begin
						state_q <= S_OUT;
					end
				end

				S_STEP_RD: begin
					state_q <= S_STEP_CHK;
				end

				S_STEP_CHK: begin
					res_exp_q <= exp_sat;
					state_q   <= S_OUT;
				end

				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_status_q;
						m_tdata  <= {3'd0, res_exp_q, res_prog_q, res_ip_q, res_door_q};
						state_q  <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Commit of a matched step, shared by new and existing attempts.
			if (upd_go) begin
				door_q                 <= dr_idx;
				slot_valid_q[upd_slot] <= !opened;
				res_door_q             <= 2'(int'(dr_idx));
				res_ip_q               <= ip_q;
				res_prog_q             <= 6'(new_prog);
				if (opened) begin
					res_status_q <= ST_OPENED;
				end else begin
					res_status_q <= upd_new ? ST_STARTED : ST_ADVANCED;
				end
			end
		end
	end

	// A packet transfer always starts with the slot pass.
	`ASSERT_NEXT(a_pkt_scan, s_tvalid && s_tready && (s_tuser == CMD_PACKET),
		state_q == S_SCAN)
	// Timeouts are counted at most once per slot already read.
	`ASSERT_IMPL(a_exp_bound, state_q == S_SCAN, exp_cnt_q <= cnt_q)
	// The attempt found for the source stays live until its step is checked.
	`ASSERT_IMPL(a_found_live,
		found_q && ((state_q == S_SCAN) || (state_q == S_STEP_RD) ||
		(state_q == S_STEP_CHK)), slot_valid_q[slot_q])

endmodule
